@@ rtl/core/lssr_pkg.sv @@
// Shared types, register indexes and constants of the lamp soft-start current ramp.
`timescale 1ns / 1ps
package lssr_pkg;

  localparam int unsigned MvW         = 16;
  localparam int unsigned CfgDataW    = 16;
  localparam int unsigned CfgIdxW     = 3;

  localparam logic [MvW-1:0] DownStepMv  = MvW'(50);
  localparam logic [MvW-1:0] StopLevelMv = MvW'(5);
  localparam logic [MvW-1:0] CmdMax      = '1;

  typedef enum logic [1:0] {
    OP_START     = 2'd0,
    OP_UP_VOLT   = 2'd1,
    OP_UP_CURR   = 2'd2,
    OP_DOWN_VOLT = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ACT_SET        = 3'd0,
    ACT_READ_I     = 3'd1,
    ACT_DONE       = 3'd2,
    ACT_NO_LOAD    = 3'd3,
    ACT_CANT_SET   = 3'd4,
    ACT_STEP_DOWN  = 3'd5,
    ACT_LAST_DOWN  = 3'd6,
    ACT_SWITCH_OFF = 3'd7
  } action_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_TARGET_CURRENT   = 3'd0,
    REG_STEP             = 3'd1,
    REG_CURRENT_ACCURACY = 3'd2,
    REG_FINAL_MULT       = 3'd3,
    REG_VOLT_TOLERANCE   = 3'd4,
    REG_LOAD_CHECK       = 3'd5,
    REG_MIN_LOAD_CURRENT = 3'd6,
    REG_RETRY_LIMIT      = 3'd7
  } cfg_idx_e;

  typedef struct packed {
    op_e            op;
    logic [MvW-1:0] reading;
  } in_t;

  typedef struct packed {
    action_e        action;
    logic [MvW-1:0] command_mv;
  } out_t;

  typedef struct packed {
    logic [15:0] target_current_ma;
    logic [9:0]  step_mv;
    logic [9:0]  current_accuracy_ma;
    logic [5:0]  final_multiplier;
    logic [9:0]  voltage_tolerance_mv;
    logic [15:0] load_check_mv;
    logic [15:0] min_load_current_ma;
    logic [3:0]  retry_limit;
  } cfg_t;

  localparam cfg_t CfgReset = '{
    target_current_ma:    16'd1000,
    step_mv:              10'd200,
    current_accuracy_ma:  10'd10,
    final_multiplier:     6'd20,
    voltage_tolerance_mv: 10'd50,
    load_check_mv:        16'd2000,
    min_load_current_ma:  16'd30,
    retry_limit:          4'd10
  };

endpackage

@@ rtl/core/lamp_soft_start_current_ramp_unit.sv @@
// Top level of the lamp soft-start current ramp: request and result registers.
//
//   channel | direction | handshake             | payload
//   --------+-----------+-----------------------+-----------------------------
//   in      | sink      | in_valid_i/in_stall_o | in_data_i  (op, reading)
//   out     | source    | out_valid_o/out_stall_i | out_data_o (action, command_mv)
//   cfg     | sink      | cfg_we_i              | cfg_idx_i, cfg_wdata_i
//
// One request per cycle sustained while the result is not stalled; a result
// is presented once its request has passed the request register, then decision
// logic into the result register. It is taken at an edge where out_stall_i is low.
// Ramp state is updated as a request moves into the result register.
// A stalled result holds; the request register keeps taking requests while empty
// or while its request moves on in the same cycle.
// Reset clears the ramp state and restores register defaults; no clearing pass.
`timescale 1ns / 1ps
module lamp_soft_start_current_ramp_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [lssr_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [lssr_pkg::CfgDataW-1:0] cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  lssr_pkg::in_t                 in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output lssr_pkg::out_t                out_data_o
);
  import lssr_pkg::*;

  cfg_t cfg;
  out_t res;

  logic req_valid_q, req_valid_d;
  in_t  req_q;
  logic out_valid_q, out_valid_d;
  out_t out_q;
  logic adv;
  logic in_acc;

  assign adv         = req_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o  = req_valid_q && !adv;
  assign in_acc      = in_valid_i && !in_stall_o;
  assign req_valid_d = in_acc || (req_valid_q && !adv);
  assign out_valid_d = adv || (out_valid_q && out_stall_i);

  lssr_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  lssr_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .adv_i  (adv),
    .cfg_i  (cfg),
    .req_i  (req_q),
    .res_o  (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      req_valid_q <= req_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      req_q <= in_data_i;
    end
    if (adv) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

@@ rtl/core/lssr_cfg.sv @@
// Configuration register file of the lamp soft-start current ramp.
`timescale 1ns / 1ps
module lssr_cfg (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [lssr_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [lssr_pkg::CfgDataW-1:0] cfg_wdata_i,
  output lssr_pkg::cfg_t                cfg_o
);
  import lssr_pkg::*;

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        REG_TARGET_CURRENT:   cfg_d.target_current_ma    = cfg_wdata_i;
        REG_STEP:             cfg_d.step_mv              = cfg_wdata_i[9:0];
        REG_CURRENT_ACCURACY: cfg_d.current_accuracy_ma  = cfg_wdata_i[9:0];
        REG_FINAL_MULT:       cfg_d.final_multiplier     = cfg_wdata_i[5:0];
        REG_VOLT_TOLERANCE:   cfg_d.voltage_tolerance_mv = cfg_wdata_i[9:0];
        REG_LOAD_CHECK:       cfg_d.load_check_mv        = cfg_wdata_i;
        REG_MIN_LOAD_CURRENT: cfg_d.min_load_current_ma  = cfg_wdata_i;
        REG_RETRY_LIMIT:      cfg_d.retry_limit          = cfg_wdata_i[3:0];
        default:              cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CfgReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

@@ rtl/core/lssr_core.sv @@
// Ramp state registers and the combinational decision logic for one request.
`timescale 1ns / 1ps
module lssr_core (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           adv_i,
  input  lssr_pkg::cfg_t cfg_i,
  input  lssr_pkg::in_t  req_i,
  output lssr_pkg::out_t res_o
);
  import lssr_pkg::*;

  logic [MvW-1:0] cmd_q, cmd_d;
  logic [3:0]     retries_q, retries_d;
  logic           final_q, final_d;

  logic [MvW-1:0] rd;
  logic [MvW-1:0] diff;
  logic [MvW:0]   rd_plus_acc;
  logic [MvW-1:0] boost;
  logic [MvW:0]   sum_step;
  logic [MvW:0]   sum_boost;
  logic [MvW-1:0] up_step;
  logic [MvW-1:0] up_boost;
  logic [MvW-1:0] down_val;
  out_t           res;

  assign rd          = req_i.reading;
  assign diff        = (cmd_q >= rd) ? (cmd_q - rd) : (rd - cmd_q);
  assign rd_plus_acc = {1'b0, rd} + {7'd0, cfg_i.current_accuracy_ma};
  assign boost       = MvW'(cfg_i.step_mv * cfg_i.final_multiplier);
  assign sum_step    = {1'b0, cmd_q} + {7'd0, cfg_i.step_mv};
  assign sum_boost   = {1'b0, cmd_q} + {1'b0, boost};
  assign up_step     = sum_step[MvW] ? CmdMax : sum_step[MvW-1:0];
  assign up_boost    = sum_boost[MvW] ? CmdMax : sum_boost[MvW-1:0];
  assign down_val    = (rd > DownStepMv) ? (rd - DownStepMv) : '0;

  always_comb begin
    cmd_d          = cmd_q;
    retries_d      = retries_q;
    final_d        = final_q;
    res.action     = ACT_SET;
    res.command_mv = '0;
    unique case (req_i.op)
      OP_START: begin
        cmd_d          = {6'd0, cfg_i.step_mv};
        retries_d      = cfg_i.retry_limit;
        final_d        = 1'b0;
        res.command_mv = {6'd0, cfg_i.step_mv};
      end
      OP_UP_VOLT: begin
        priority if (diff <= {6'd0, cfg_i.voltage_tolerance_mv}) begin
          res.action = ACT_READ_I;
        end else if (retries_q == '0) begin
          res.action = ACT_CANT_SET;
        end else begin
          retries_d      = retries_q - 4'd1;
          res.command_mv = cmd_q;
        end
      end
      OP_UP_CURR: begin
        priority if (cmd_q >= cfg_i.load_check_mv && rd < cfg_i.min_load_current_ma) begin
          res.action = ACT_NO_LOAD;
        end else if (cmd_q < cfg_i.load_check_mv && rd < cfg_i.target_current_ma) begin
          cmd_d          = up_step;
          res.command_mv = up_step;
        end else if (final_q) begin
          res.action = ACT_DONE;
        end else if (rd_plus_acc >= {1'b0, cfg_i.target_current_ma}) begin
          cmd_d          = up_boost;
          final_d        = 1'b1;
          res.command_mv = up_boost;
        end else begin
          cmd_d          = up_step;
          res.command_mv = up_step;
        end
      end
      OP_DOWN_VOLT: begin
        if (rd > StopLevelMv) begin
          res.action     = (down_val > StopLevelMv) ? ACT_STEP_DOWN : ACT_LAST_DOWN;
          res.command_mv = down_val;
        end else begin
          res.action = ACT_SWITCH_OFF;
        end
      end
      default: res.action = ACT_SET;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd_q     <= '0;
      retries_q <= '0;
      final_q   <= 1'b0;
    end else if (adv_i) begin
      cmd_q     <= cmd_d;
      retries_q <= retries_d;
      final_q   <= final_d;
    end
  end

  assign res_o = res;

endmodule

@@ bench/tb_lamp_soft_start_current_ramp_unit.sv @@
// Testbench of the lamp soft-start current ramp unit: random requests checked against a ramp tracker.
`timescale 1ns / 1ps
module tb_lamp_soft_start_current_ramp_unit;
  import lssr_pkg::*;

  localparam int unsigned CycleLimit = 500000;
  localparam int unsigned HoldCycles = 300;
  localparam int unsigned Phases     = 12;
  localparam int unsigned PhaseItems = 50;

  class ramp_tracker;
    cfg_t         regs;
    logic [15:0]  level_mv;
    logic [3:0]   retry_budget;
    logic         boost_done;
    out_t         pending_actions[$];
    action_e      last_action;
    logic [15:0]  last_command;
    int unsigned  mismatches;

    function new();
      regs         = CfgReset;
      level_mv     = '0;
      retry_budget = '0;
      boost_done   = 1'b0;
      last_action  = ACT_SET;
      last_command = '0;
      mismatches   = 0;
    endfunction

    function void set_reg(cfg_idx_e idx, logic [15:0] value);
      case (idx)
        REG_TARGET_CURRENT:   regs.target_current_ma    = value;
        REG_STEP:             regs.step_mv              = value[9:0];
        REG_CURRENT_ACCURACY: regs.current_accuracy_ma  = value[9:0];
        REG_FINAL_MULT:       regs.final_multiplier     = value[5:0];
        REG_VOLT_TOLERANCE:   regs.voltage_tolerance_mv = value[9:0];
        REG_LOAD_CHECK:       regs.load_check_mv        = value;
        REG_MIN_LOAD_CURRENT: regs.min_load_current_ma  = value;
        default:              regs.retry_limit          = value[3:0];
      endcase
    endfunction

    function logic [15:0] raise_level(int unsigned add);
      int unsigned sum;
      sum = int'(level_mv) + add;
      return (sum > 65535) ? CmdMax : sum[15:0];
    endfunction

    function out_t next_action(in_t req);
      out_t        res;
      int unsigned lvl;
      int unsigned rd;
      int unsigned diff;
      res.action     = ACT_SET;
      res.command_mv = '0;
      lvl = level_mv;
      rd  = req.reading;
      case (req.op)
        OP_START: begin
          level_mv       = {6'd0, regs.step_mv};
          retry_budget   = regs.retry_limit;
          boost_done     = 1'b0;
          res.command_mv = level_mv;
        end
        OP_UP_VOLT: begin
          diff = (lvl >= rd) ? lvl - rd : rd - lvl;
          if (diff <= regs.voltage_tolerance_mv) begin
            res.action = ACT_READ_I;
          end else if (retry_budget == 4'd0) begin
            res.action = ACT_CANT_SET;
          end else begin
            retry_budget   = retry_budget - 4'd1;
            res.command_mv = level_mv;
          end
        end
        OP_UP_CURR: begin
          if (lvl >= regs.load_check_mv && rd < regs.min_load_current_ma) begin
            res.action = ACT_NO_LOAD;
          end else if (lvl < regs.load_check_mv && rd < regs.target_current_ma) begin
            level_mv       = raise_level(regs.step_mv);
            res.command_mv = level_mv;
          end else if (boost_done) begin
            res.action = ACT_DONE;
          end else if (rd + regs.current_accuracy_ma >= regs.target_current_ma) begin
            level_mv       = raise_level(regs.step_mv * regs.final_multiplier);
            boost_done     = 1'b1;
            res.command_mv = level_mv;
          end else begin
            level_mv       = raise_level(regs.step_mv);
            res.command_mv = level_mv;
          end
        end
        default: begin
          if (rd > StopLevelMv) begin
            diff           = (rd > DownStepMv) ? rd - DownStepMv : 0;
            res.action     = (diff > StopLevelMv) ? ACT_STEP_DOWN : ACT_LAST_DOWN;
            res.command_mv = diff[15:0];
          end else begin
            res.action = ACT_SWITCH_OFF;
          end
        end
      endcase
      return res;
    endfunction

    function void note_request(in_t req);
      out_t exp;
      exp = next_action(req);
      pending_actions.push_back(exp);
      last_action  = exp.action;
      last_command = exp.command_mv;
    endfunction

    task report_mismatch(string msg);
      $display("MISMATCH at %0t: %s", $realtime, msg);
      mismatches++;
    endtask

    task check_result(out_t got);
      out_t exp;
      if (pending_actions.size() == 0) begin
        report_mismatch($sformatf("unexpected result action %0d command %0d",
                                  got.action, got.command_mv));
      end else begin
        exp = pending_actions.pop_front();
        if (got.action !== exp.action)
          report_mismatch($sformatf("action %0d, expected %0d", got.action, exp.action));
        if (got.command_mv !== exp.command_mv)
          report_mismatch($sformatf("command_mv %0d, expected %0d",
                                    got.command_mv, exp.command_mv));
      end
    endtask
  endclass

  logic         clk_i;
  logic         rst_ni;
  logic         cfg_we_i;
  cfg_idx_e     cfg_idx_i;
  logic [15:0]  cfg_wdata_i;
  logic         in_valid_i;
  logic         in_stall_o;
  in_t          in_data_i;
  logic         out_valid_o;
  logic         out_stall_i;
  out_t         out_data_o;

  ramp_tracker  sb;
  int unsigned  items_sent;
  int unsigned  phase_end;
  int unsigned  cycle_count;
  bit           quiet;
  bit           hold_req;

  lamp_soft_start_current_ramp_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("Some tests failed");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) sb.check_result(out_data_o);
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (quiet || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  initial begin
    int unsigned n;
    out_stall_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (hold_req) begin
        out_stall_i <= 1'b1;
        repeat (HoldCycles) @(posedge clk_i);
        hold_req = 1'b0;
      end else begin
        n = pick_gap();
        if (n > 0) begin
          out_stall_i <= 1'b1;
          repeat (n) @(posedge clk_i);
        end
      end
      out_stall_i <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
  end

  task automatic send_request(op_e op, logic [15:0] reading);
    in_t         req;
    int unsigned gap;
    req.op      = op;
    req.reading = reading;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= req;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sb.note_request(req);
    items_sent++;
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.pending_actions.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [15:0] value);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    sb.set_reg(idx, value);
  endtask

  task automatic configure(int unsigned phase);
    int unsigned lo;
    int unsigned hi;
    int unsigned span;
    int unsigned r;
    logic [15:0] value;
    for (int i = 0; i < 8; i++) begin
      case (cfg_idx_e'(i))
        REG_TARGET_CURRENT:   begin lo = 0; hi = 65535; span = 5000; end
        REG_STEP:             begin lo = 1; hi = 1000;  span = 1000; end
        REG_CURRENT_ACCURACY: begin lo = 0; hi = 1000;  span = 1000; end
        REG_FINAL_MULT:       begin lo = 1; hi = 63;    span = 63;   end
        REG_VOLT_TOLERANCE:   begin lo = 0; hi = 1000;  span = 200;  end
        REG_LOAD_CHECK:       begin lo = 0; hi = 65535; span = 8000; end
        REG_MIN_LOAD_CURRENT: begin lo = 0; hi = 65535; span = 200;  end
        default:              begin lo = 0; hi = 15;    span = 15;   end
      endcase
      r = (phase == 0) ? 0 : (phase == 1) ? 99 : $urandom_range(0, 99);
      if (r < 12) value = 16'(lo);
      else if (r >= 88) value = 16'(hi);
      else if (r < 20) value = 16'($urandom);
      else value = 16'($urandom_range(lo, span));
      write_reg(cfg_idx_e'(i), value);
    end
    cfg_we_i <= 1'b0;
  endtask

  task automatic run_ramp();
    int unsigned limit;
    int          v;
    int          tol;
    int unsigned target;
    int unsigned r;
    send_request(OP_START, 16'($urandom));
    limit = $urandom_range(4, 30);
    for (int k = 0; k < limit && items_sent < phase_end; k++) begin
      tol = sb.regs.voltage_tolerance_mv;
      r   = $urandom_range(0, 9);
      if (r < 8) v = int'(sb.level_mv) + int'($urandom_range(0, 2 * tol)) - tol;
      else if (r == 8) v = int'(sb.level_mv) + tol + int'($urandom_range(1, 3));
      else v = $urandom_range(0, 65535);
      v = (v < 0) ? 0 : (v > 65535) ? 65535 : v;
      send_request(OP_UP_VOLT, 16'(v));
      if (sb.last_action == ACT_CANT_SET) break;
      if (sb.last_action == ACT_READ_I) begin
        target = sb.regs.target_current_ma;
        r      = $urandom_range(0, 99);
        if (r < 45) v = $urandom_range(0, target);
        else if (r < 65) v = int'(target) - int'($urandom_range(0, sb.regs.current_accuracy_ma));
        else if (r < 80) v = $urandom_range(target, 65535);
        else if (r < 90) v = $urandom_range(0, sb.regs.min_load_current_ma);
        else v = $urandom_range(0, 65535);
        v = (v < 0) ? 0 : v;
        send_request(OP_UP_CURR, 16'(v));
        if (sb.last_action inside {ACT_DONE, ACT_NO_LOAD}) break;
      end
    end
  endtask

  task automatic run_ramp_down();
    int unsigned v;
    v = ($urandom_range(0, 3) == 0) ? int'(sb.level_mv) : $urandom_range(0, 800);
    for (int k = 0; k < 30 && items_sent < phase_end; k++) begin
      send_request(OP_DOWN_VOLT, 16'(v));
      if (sb.last_action == ACT_SWITCH_OFF) break;
      v = int'(sb.last_command) + $urandom_range(0, 2);
    end
  endtask

  initial begin
    int unsigned r;
    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_idx_i   = REG_TARGET_CURRENT;
    cfg_wdata_i = '0;
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    cycle_count = 0;
    items_sent  = 0;
    quiet       = 1'b0;
    hold_req    = 1'b0;
    sb = new();
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    write_reg(REG_STEP, 16'd1000);
    write_reg(REG_FINAL_MULT, 16'd63);
    write_reg(REG_RETRY_LIMIT, 16'd1);
    cfg_we_i <= 1'b0;

    // readbacks before any start, then a full ramp with saturation and ramp-down
    send_request(OP_UP_VOLT, 16'd0);
    send_request(OP_UP_CURR, 16'hFFFF);
    send_request(OP_START, 16'd0);
    send_request(OP_UP_CURR, 16'd0);
    send_request(OP_UP_CURR, 16'd10);
    send_request(OP_UP_CURR, 16'd500);
    send_request(OP_UP_CURR, 16'd990);
    send_request(OP_UP_CURR, 16'hFFFF);
    send_request(OP_UP_VOLT, 16'd65485);
    send_request(OP_UP_VOLT, 16'd65484);
    send_request(OP_UP_VOLT, 16'd0);
    send_request(OP_DOWN_VOLT, 16'hFFFF);
    send_request(OP_DOWN_VOLT, 16'd56);
    send_request(OP_DOWN_VOLT, 16'd55);
    send_request(OP_DOWN_VOLT, 16'd30);
    send_request(OP_DOWN_VOLT, 16'd6);
    send_request(OP_DOWN_VOLT, 16'd5);
    send_request(OP_DOWN_VOLT, 16'd0);
    send_request(OP_START, 16'hFFFF);

    for (int unsigned phase = 0; phase < Phases; phase++) begin
      drain();
      configure(phase);
      quiet = (phase == 4);
      if (phase == 6) hold_req = 1'b1;
      phase_end = items_sent + PhaseItems;
      while (items_sent < phase_end) begin
        r = $urandom_range(0, 99);
        if (r < 65) run_ramp();
        else if (r < 85) run_ramp_down();
        else send_request(op_e'($urandom_range(0, 3)), 16'($urandom));
      end
    end
    drain();
    repeat (8) @(posedge clk_i);

    if (sb.mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
